FILE: rtl/adof_pkg.sv
// Package for the audio decode and overlapped framing block.
// Holds payload structs, encoding codes and shared size constants.
// No dependencies.
package adof_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam int ADV_MAX       = 4096;
    localparam int HEAD_BYTES    = 16;
    localparam int QUEUE_DEPTH   = 4;

    // Stream encoding codes
    localparam logic [2:0] ENC_ULAW   = 3'd0;
    localparam logic [2:0] ENC_ALAW   = 3'd1;
    localparam logic [2:0] ENC_LIN8   = 3'd2;
    localparam logic [2:0] ENC_LIN16  = 3'd3;
    localparam logic [2:0] ENC_SPHERE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_ENCODING = 2'd0;
    localparam logic [1:0] REG_LENGTH   = 2'd1;
    localparam logic [1:0] REG_ADVANCE  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               not_eof;
    } out_item_t;

    // Request passed from the front end to the framing back end
    typedef struct packed {
        logic        eos;
        logic [15:0] sample;
    } q_entry_t;

endpackage

FILE: rtl/adof_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module adof_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/adof_front.sv
// Front end: accepts stream bytes, skips the SPHERE header, pairs lin16 bytes
// and decodes samples into queue requests. Depends on adof_pkg.
module adof_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          encoding,
    input  logic                accept,
    input  adof_pkg::in_item_t  item,
    output logic                push,
    output adof_pkg::q_entry_t  entry
);

    typedef enum logic [1:0] {
        P_LEAD,
        P_DIGITS,
        P_DONE
    } parse_t;

    logic        phase_reg, phase_next;
    logic [7:0]  hold_reg, hold_next;
    logic        any_reg, any_next;
    logic [4:0]  hidx_reg, hidx_next;
    logic [13:0] hlen_reg, hlen_next;
    logic [13:0] skip_reg, skip_next;
    parse_t      pphase_reg, pphase_next;
    logic        neg_reg, neg_next;

    function automatic logic [15:0] ulaw_decode(input logic [7:0] b);
        logic [7:0]  u;
        logic [15:0] t;
        logic [15:0] mag;
        u   = ~b;
        t   = (16'({u[3:0], 3'b000}) + 16'h0084) << u[6:4];
        mag = t - 16'h0084;
        return u[7] ? (16'h0000 - mag) : mag;
    endfunction

    function automatic logic [15:0] alaw_decode(input logic [7:0] b);
        logic [7:0]  a;
        logic [15:0] t;
        a = b ^ 8'h55;
        t = 16'({a[3:0], 4'b0000});
        if (a[6:4] == 3'd0)
        begin
            t = t + 16'd8;
        end
        else
        begin
            t = (t + 16'h0108) << (a[6:4] - 3'd1);
        end
        return a[7] ? t : (16'h0000 - t);
    endfunction

    logic [7:0] b;
    logic       is_digit;
    logic       is_space;
    assign b        = item.data_byte;
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign is_space = (b == 8'h20) || ((b >= 8'd9) && (b <= 8'd13));

    // Byte classification and next state
    always_comb
    begin
        phase_next  = phase_reg;
        hold_next   = hold_reg;
        any_next    = any_reg;
        hidx_next   = hidx_reg;
        hlen_next   = hlen_reg;
        skip_next   = skip_reg;
        pphase_next = pphase_reg;
        neg_next    = neg_reg;
        push        = 1'b0;
        entry       = '0;
        if (accept)
        begin
            if (item.end_of_stream)
            begin
                push        = 1'b1;
                entry.eos   = 1'b1;
                phase_next  = 1'b0;
                hold_next   = '0;
                any_next    = 1'b0;
                hidx_next   = '0;
                hlen_next   = '0;
                skip_next   = '0;
                pphase_next = P_LEAD;
                neg_next    = 1'b0;
            end
            else if (encoding == adof_pkg::ENC_LIN16)
            begin
                if (!phase_reg)
                begin
                    hold_next  = b;
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next   = 1'b0;
                    push         = 1'b1;
                    entry.sample = {b, hold_reg};
                    any_next     = 1'b1;
                end
            end
            else
            begin
                phase_next = 1'b0;
                if ((encoding == adof_pkg::ENC_SPHERE) && !any_reg &&
                    ((hidx_reg < 5'(adof_pkg::HEAD_BYTES)) || (skip_reg != '0)))
                begin
                    if (hidx_reg < 5'(adof_pkg::HEAD_BYTES))
                    begin
                        // Bytes 11 to 14 carry the decimal header length
                        if ((hidx_reg >= 5'd11) && (hidx_reg <= 5'd14))
                        begin
                            unique case (pphase_reg)
                                P_LEAD:
                                begin
                                    if (!is_space)
                                    begin
                                        if ((b == 8'h2B) || (b == 8'h2D))
                                        begin
                                            neg_next    = (b == 8'h2D);
                                            pphase_next = P_DIGITS;
                                        end
                                        else if (is_digit)
                                        begin
                                            hlen_next   = 14'(b - 8'h30);
                                            pphase_next = P_DIGITS;
                                        end
                                        else
                                        begin
                                            pphase_next = P_DONE;
                                        end
                                    end
                                end
                                P_DIGITS:
                                begin
                                    if (is_digit)
                                    begin
                                        hlen_next = 14'((hlen_reg * 14'd10) +
                                                        14'(b - 8'h30));
                                    end
                                    else
                                    begin
                                        pphase_next = P_DONE;
                                    end
                                end
                                P_DONE:
                                begin
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        hidx_next = hidx_reg + 5'd1;
                        if (hidx_reg == 5'(adof_pkg::HEAD_BYTES - 1))
                        begin
                            skip_next = (!neg_reg &&
                                         (hlen_reg > 14'(adof_pkg::HEAD_BYTES)))
                                        ? hlen_reg - 14'(adof_pkg::HEAD_BYTES) : '0;
                        end
                    end
                    else
                    begin
                        skip_next = skip_reg - 14'd1;
                    end
                end
                else
                begin
                    push     = 1'b1;
                    any_next = 1'b1;
                    if (encoding == adof_pkg::ENC_ALAW)
                    begin
                        entry.sample = alaw_decode(b);
                    end
                    else if (encoding == adof_pkg::ENC_LIN8)
                    begin
                        entry.sample = {8'h00, b};
                    end
                    else
                    begin
                        entry.sample = ulaw_decode(b);
                    end
                end
            end
        end
    end

    // Front end state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 1'b0;
            hold_reg   <= '0;
            any_reg    <= 1'b0;
            hidx_reg   <= '0;
            hlen_reg   <= '0;
            skip_reg   <= '0;
            pphase_reg <= P_LEAD;
            neg_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hold_reg   <= hold_next;
            any_reg    <= any_next;
            hidx_reg   <= hidx_next;
            hlen_reg   <= hlen_next;
            skip_reg   <= skip_next;
            pphase_reg <= pphase_next;
            neg_reg    <= neg_next;
        end
    end

endmodule

FILE: rtl/adof_queue.sv
// Short request queue between the front end and the framing back end.
// Depends on adof_pkg.
module adof_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  adof_pkg::q_entry_t push_entry,
    input  logic               pop,
    output logic               full,
    output logic               nonempty,
    output adof_pkg::q_entry_t head
);

    localparam int DEPTH = adof_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    adof_pkg::q_entry_t slot_reg [DEPTH];
    logic [PW-1:0]      wptr_reg, rptr_reg;
    logic [PW:0]        count_reg;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = slot_reg[rptr_reg];

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

FILE: rtl/adof_back.sv
// Framing back end: stores samples in the frame RAM, emits frames while
// shifting the kept part down, and emits the zero frame at end of stream.
// Depends on adof_pkg and adof_ram.
module adof_back #(
    parameter int MAX_FRAME = adof_pkg::MAX_FRAME_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [6:0]          frame_length,
    input  logic [12:0]         frame_advance,
    input  logic                q_nonempty,
    input  adof_pkg::q_entry_t  q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output adof_pkg::out_item_t out_data
);

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam logic [6:0]  LEN_MAX = 7'(MAX_FRAME);
    localparam logic [12:0] ADV_TOP = 13'(adof_pkg::ADV_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SEND,
        S_ZERO
    } state_t;

    state_t              state_reg;
    logic [12:0]         fill_reg;
    logic                first_reg;
    logic [6:0]          idx_reg;
    logic [MAX_FRAME-1:0] valid_reg;
    logic                rd_valid_reg;
    logic                out_valid_reg;
    adof_pkg::out_item_t out_reg;

    logic [6:0]  len;
    logic [12:0] adv;
    logic [12:0] len13;
    logic [12:0] fill_inc;
    logic        adv_lt_len;
    logic [12:0] base;
    logic [12:0] fresh;
    logic        last_idx;

    // Effective register values
    always_comb
    begin
        len = frame_length;
        if (len == 7'd0)
        begin
            len = 7'd1;
        end
        else if (len > LEN_MAX)
        begin
            len = LEN_MAX;
        end
        adv = frame_advance;
        if (adv == 13'd0)
        begin
            adv = 13'd1;
        end
        else if (adv > ADV_TOP)
        begin
            adv = ADV_TOP;
        end
    end

    assign len13      = 13'(len);
    assign fill_inc   = fill_reg + 13'd1;
    assign adv_lt_len = (adv < len13);
    assign base       = adv_lt_len ? len13 - adv : '0;
    assign fresh      = adv_lt_len ? adv : len13;
    assign last_idx   = ((idx_reg + 7'd1) == len);

    // Frame RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [15:0]   ram_rdata;
    logic [15:0]   rd_word;
    logic [12:0]   store_addr;
    logic          take_sample;

    assign take_sample = (state_reg == S_IDLE) && q_nonempty && !q_head.eos;
    assign store_addr  = first_reg ? fill_reg : base + fill_reg;
    assign rd_word     = rd_valid_reg ? ram_rdata : 16'h0000;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (take_sample)
        begin
            ram_we    = first_reg ? (fill_reg < len13) : (fill_reg < fresh);
            ram_waddr = store_addr[AW-1:0];
            ram_wdata = q_head.sample;
        end
        else if ((state_reg == S_LOAD) && adv_lt_len && (13'(idx_reg) >= adv))
        begin
            // Kept samples move down by the advance as they are read out
            ram_we    = 1'b1;
            ram_waddr = AW'(13'(idx_reg) - adv);
            ram_wdata = rd_word;
        end
    end

    adof_ram #(
        .WIDTH(16),
        .DEPTH(MAX_FRAME)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign q_pop     = (state_reg == S_IDLE) && q_nonempty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequencer, frame state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            first_reg     <= 1'b1;
            idx_reg       <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (q_nonempty)
                    begin
                        if (q_head.eos)
                        begin
                            state_reg <= S_ZERO;
                        end
                        else
                        begin
                            fill_reg <= fill_inc;
                            if (first_reg ? (fill_inc >= len13) : (fill_inc >= adv))
                            begin
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                S_READ:
                begin
                    rd_valid_reg <= valid_reg[idx_reg[AW-1:0]];
                    state_reg    <= S_LOAD;
                end
                S_LOAD:
                begin
                    out_reg.sample  <= rd_word;
                    out_reg.last    <= last_idx;
                    out_reg.not_eof <= 1'b1;
                    out_valid_reg   <= 1'b1;
                    state_reg       <= S_SEND;
                end
                S_SEND:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_idx)
                        begin
                            fill_reg  <= '0;
                            first_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 7'd1;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_ZERO:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg.sample  <= '0;
                        out_reg.last    <= last_idx;
                        out_reg.not_eof <= 1'b0;
                        out_valid_reg   <= 1'b1;
                    end
                    else if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_idx)
                        begin
                            // End of stream returns the framer to its start
                            fill_reg  <= '0;
                            first_reg <= 1'b1;
                            valid_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 7'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/audio_decode_overlap_framer_core.sv
// Top level of the audio decode and overlapped framing block.
// Depends on adof_pkg, adof_front, adof_queue, adof_back and adof_ram.
//
// Bytes are taken at one per cycle into a front end that decodes u-law,
// A-law, lin8 or lin16 samples (skipping a SPHERE header) and places them in
// a four-entry queue. The framing back end takes one sample per cycle from
// the queue while idle; when a frame is due it reads it out of the frame RAM,
// one result sample at a time (RAM read, output load, handshake), shifting
// the kept samples down in the same pass. Input stalls once the queue fills.
// The frame RAM needs no clearing pass: a valid bit per entry makes unwritten
// entries read as zero, and both reset and end of stream clear those bits.
module audio_decode_overlap_framer_core #(
    parameter int MAX_FRAME = adof_pkg::MAX_FRAME_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  adof_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output adof_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_wdata
);

    logic [2:0]  encoding_reg;
    logic [6:0]  length_reg;
    logic [12:0] advance_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_reg <= adof_pkg::ENC_ULAW;
            length_reg   <= 7'd64;
            advance_reg  <= 13'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                adof_pkg::REG_ENCODING: encoding_reg <= cfg_wdata[2:0];
                adof_pkg::REG_LENGTH:   length_reg   <= cfg_wdata[6:0];
                adof_pkg::REG_ADVANCE:  advance_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_nonempty;
    adof_pkg::q_entry_t q_in;
    adof_pkg::q_entry_t q_head;
    logic               accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    adof_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .encoding(encoding_reg),
        .accept  (accept),
        .item    (in_data),
        .push    (q_push),
        .entry   (q_in)
    );

    adof_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_entry(q_in),
        .pop       (q_pop),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    adof_back #(
        .MAX_FRAME(MAX_FRAME)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_length (length_reg),
        .frame_advance(advance_reg),
        .q_nonempty   (q_nonempty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule

FILE: rtl/adof_checker.sv
// Port-level checks for the audio decode and overlapped framing block,
// bound to the top level. Depends on adof_pkg.
module adof_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input adof_pkg::out_item_t out_data
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // The end-of-stream frame carries only zero samples
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.not_eof |-> out_data.sample == 16'sd0)
        else $error("end frame sample not zero");

    // No result is offered while reset is held
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result during reset");

endmodule

bind audio_decode_overlap_framer_core adof_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

FILE: tb/tb_audio_decode_overlap_framer_core.sv
// Self-checking testbench for audio_decode_overlap_framer_core.
// Depends on adof_pkg and the block itself; it predicts every frame sample from
// its own model of the decoder and framer and checks each result in order.
module tb_audio_decode_overlap_framer_core;

    localparam logic [2:0] ENC_BAD = 3'd7;
    localparam int SETTLE_CYCLES = 300;
    localparam int STORE_DEPTH = adof_pkg::MAX_FRAME_DEF;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    adof_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    adof_pkg::out_item_t out_data;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [12:0]         cfg_wdata;

    audio_decode_overlap_framer_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Expected frame samples, oldest first.
    adof_pkg::out_item_t frame_q[$];
    int        fail_count;
    bit        quiet;
    int        hold_off;
    int        rx_burst;

    // Shadow copy of the registers and of the framer state.
    logic [2:0]  enc_r;
    logic [6:0]  len_r;
    logic [12:0] adv_r;
    logic [15:0] store[STORE_DEPTH];
    int          fill;
    bit          first;
    logic [7:0]  low_hold;
    bit          pair_phase;
    int          hdr_idx;
    int          hdr_len;
    int          skip_left;
    int          num_phase;
    bit          num_neg;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Mismatch report: one line each, counted.
    task automatic report(input string msg);
        fail_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    function automatic int eff_len();
        if (len_r == 0) return 1;
        if (len_r > STORE_DEPTH) return STORE_DEPTH;
        return len_r;
    endfunction

    function automatic int eff_adv();
        if (adv_r == 0) return 1;
        if (adv_r > adof_pkg::ADV_MAX) return adof_pkg::ADV_MAX;
        return adv_r;
    endfunction

    function automatic logic [15:0] ulaw_to_lin(input logic [7:0] b);
        logic [31:0] u;
        logic [31:0] t;
        logic [31:0] mag;
        u   = {24'd0, ~b};
        t   = (({28'd0, u[3:0]} << 3) + 32'h84) << u[6:4];
        mag = t - 32'h84;
        return u[7] ? 16'(-mag) : mag[15:0];
    endfunction

    function automatic logic [15:0] alaw_to_lin(input logic [7:0] b);
        logic [7:0]  a;
        logic [31:0] t;
        a = b ^ 8'h55;
        t = {28'd0, a[3:0]} << 4;
        if (a[6:4] == 0)
            t = t + 8;
        else
            t = (t + 32'h108) << (a[6:4] - 1);
        return a[7] ? t[15:0] : 16'(-t);
    endfunction

    function automatic void clear_framer();
        foreach (store[i]) store[i] = '0;
        fill = 0;
        first = 1'b1;
        low_hold = '0;
        pair_phase = 1'b0;
        hdr_idx = 0;
        hdr_len = 0;
        skip_left = 0;
        num_phase = 0;
        num_neg = 1'b0;
    endfunction

    function automatic void queue_frame(input bit zero);
        adof_pkg::out_item_t r;
        int n;
        n = eff_len();
        for (int i = 0; i < n; i++)
        begin
            r.sample  = zero ? 16'sd0 : store[i];
            r.last    = (i + 1 == n);
            r.not_eof = !zero;
            frame_q.push_back(r);
        end
    endfunction

    // Place one decoded sample; a complete group emits a frame and shifts.
    function automatic void take_sample(input logic [15:0] s);
        int n;
        int a;
        int base;
        int fresh;
        n = eff_len();
        a = eff_adv();
        if (first)
        begin
            if (fill < n) store[fill] = s;
            fill++;
            if (fill < n) return;
        end
        else
        begin
            base  = (n > a) ? n - a : 0;
            fresh = (n > a) ? a : n;
            if (fill < fresh) store[base + fill] = s;
            fill++;
            if (fill < a) return;
        end
        queue_frame(1'b0);
        first = 1'b0;
        fill = 0;
        if (a < n)
            for (int i = 0; i + a < n; i++) store[i] = store[i + a];
    endfunction

    // Header length field, read like atoi.
    function automatic void parse_digit(input logic [7:0] c);
        bit digit;
        digit = (c >= "0" && c <= "9");
        if (num_phase == 0)
        begin
            if (c == " " || (c >= 9 && c <= 13)) return;
            if (c == "+" || c == "-")
            begin
                num_neg = (c == "-");
                num_phase = 1;
            end
            else if (digit)
            begin
                hdr_len = c - "0";
                num_phase = 1;
            end
            else
            begin
                num_phase = 2;
            end
        end
        else if (num_phase == 1)
        begin
            if (digit) hdr_len = (hdr_len * 10 + (c - "0")) & 16'h3FFF;
            else num_phase = 2;
        end
    endfunction

    function automatic void predict_decode(input adof_pkg::in_item_t it);
        logic [7:0] b;
        b = it.data_byte;
        if (it.end_of_stream)
        begin
            queue_frame(1'b1);
            clear_framer();
            return;
        end
        if (enc_r == adof_pkg::ENC_LIN16)
        begin
            if (!pair_phase)
            begin
                low_hold = b;
                pair_phase = 1'b1;
            end
            else
            begin
                pair_phase = 1'b0;
                take_sample({b, low_hold});
            end
            return;
        end
        pair_phase = 1'b0;
        if (enc_r == adof_pkg::ENC_SPHERE && first && fill == 0 &&
            (hdr_idx < adof_pkg::HEAD_BYTES || skip_left > 0))
        begin
            if (hdr_idx < adof_pkg::HEAD_BYTES)
            begin
                if (hdr_idx >= 11 && hdr_idx <= 14) parse_digit(b);
                hdr_idx++;
                if (hdr_idx == adof_pkg::HEAD_BYTES)
                    skip_left = (!num_neg && hdr_len > adof_pkg::HEAD_BYTES)
                                ? hdr_len - adof_pkg::HEAD_BYTES : 0;
            end
            else
            begin
                skip_left--;
            end
            return;
        end
        if (enc_r == adof_pkg::ENC_ALAW) take_sample(alaw_to_lin(b));
        else if (enc_r == adof_pkg::ENC_LIN8) take_sample({8'd0, b});
        else take_sample(ulaw_to_lin(b));
    endfunction

    // Sends one request, with an occasional idle burst first.
    task automatic send_item(input logic [7:0] b, input bit eos);
        adof_pkg::in_item_t it;
        it.data_byte = b;
        it.end_of_stream = eos;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_decode(it);
    endtask

    // Waits until every expected sample is out and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == adof_pkg::REG_ENCODING) enc_r = val[2:0];
        else if (idx == adof_pkg::REG_LENGTH) len_r = val[6:0];
        else if (idx == adof_pkg::REG_ADVANCE) adv_r = val;
    endtask

    task automatic setup(input logic [2:0] enc, input logic [12:0] n,
                         input logic [12:0] a);
        write_reg(adof_pkg::REG_ENCODING, {10'd0, enc});
        write_reg(adof_pkg::REG_LENGTH, n);
        write_reg(adof_pkg::REG_ADVANCE, a);
    endtask

    // Sixteen header bytes with a four-character length field.
    task automatic send_header(input string field);
        for (int i = 0; i < 11; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < 4; i++) send_item(field[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // G.711 code extremes, short frames (overlapping for u-law).
    task automatic test_law_extremes();
        setup(adof_pkg::ENC_ULAW, 13'd4, 13'd2);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h0F, 1'b0);
        send_item(8'h00, 1'b1);
        setup(adof_pkg::ENC_ALAW, 13'd1, 13'd1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'hD5, 1'b0);
        send_item(8'h2A, 1'b1);
    endtask

    // Linear formats, advance past the frame and clamped register values.
    task automatic test_linear();
        setup(adof_pkg::ENC_LIN16, 13'd3, 13'd5);
        for (int i = 0; i < 12; i++) send_item(i[0] ? 8'hFF : 8'h00, 1'b0);
        send_item(8'h00, 1'b1);
        setup(adof_pkg::ENC_LIN8, 13'd0, 13'd0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        setup(adof_pkg::ENC_LIN8, 13'd127, 13'd8191);
        for (int i = 0; i < 66; i++) send_item(8'(i * 5), 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // Header parsing, a negative length, and an out-of-range encoding code.
    task automatic test_sphere();
        setup(adof_pkg::ENC_SPHERE, 13'd2, 13'd1);
        send_header(" 20 ");
        for (int i = 0; i < 7; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(8'h00, 1'b1);
        send_header("-100");
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'h00, 1'b1);
        send_header("x5  ");
        send_item(8'h00, 1'b1);
        setup(ENC_BAD, 13'd2, 13'd2);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // A half-built lin16 pair is dropped when the encoding changes.
    task automatic test_pair_drop();
        setup(adof_pkg::ENC_LIN16, 13'd2, 13'd2);
        send_item(8'hAB, 1'b0);
        write_reg(adof_pkg::REG_ENCODING, {10'd0, adof_pkg::ENC_LIN8});
        send_item(8'h11, 1'b0);
        send_item(8'h22, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // Random streams under random settings, headers mostly well formed.
    task automatic test_random_streams(input int phases, input bit pressure);
        int         n;
        int         hdr;
        string      field;
        logic [2:0] enc;
        for (int p = 0; p < phases; p++)
        begin
            enc = 3'($urandom_range(0, 7));
            setup(enc, 13'($urandom_range(1, 12)), 13'($urandom_range(1, 14)));
            if (pressure && p == 0)
            begin
                setup(adof_pkg::ENC_LIN8, 13'd8, 13'd8);
                hold_off = 500;
            end
            if (enc_r == adof_pkg::ENC_SPHERE)
            begin
                hdr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 9999)
                                                : $urandom_range(16, 30);
                field = $sformatf("%4d", hdr);
                send_header(field);
            end
            n = (pressure && p == 0) ? 24 : $urandom_range(4, 10);
            for (int i = 0; i < n; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Receiver: random stall bursts, and one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else if (rx_burst > 0)
        begin
            rx_burst <= rx_burst - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            rx_burst <= $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Result check against the oldest expected sample.
    always @(posedge clk)
    begin
        adof_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_q.size() == 0)
            begin
                report($sformatf("unexpected sample %0d", out_data.sample));
            end
            else
            begin
                want = frame_q.pop_front();
                if (out_data.sample !== want.sample)
                    report($sformatf("sample %0d, want %0d", out_data.sample,
                                     want.sample));
                if (out_data.last !== want.last)
                    report($sformatf("last %0b, want %0b", out_data.last, want.last));
                if (out_data.not_eof !== want.not_eof)
                    report($sformatf("not_eof %0b, want %0b", out_data.not_eof,
                                     want.not_eof));
            end
        end
    end

    // Run limit.
    initial
    begin
        #4000000;
        $display("audio_decode_overlap_framer_core test failed");
        $finish;
    end

    initial
    begin
        fail_count = 0;
        quiet      = 1'b0;
        hold_off   = 0;
        rx_burst   = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = adof_pkg::REG_ENCODING;
        cfg_wdata  = '0;
        enc_r      = adof_pkg::ENC_ULAW;
        len_r      = 7'd64;
        adv_r      = 13'd64;
        clear_framer();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_law_extremes();
        test_linear();
        test_sphere();
        test_pair_drop();
        test_random_streams(1, 1'b1);
        test_random_streams(3, 1'b0);
        quiet = 1'b1;
        test_random_streams(1, 1'b0);
        settle();

        if (fail_count == 0)
            $display("audio_decode_overlap_framer_core test passed");
        else
            $display("audio_decode_overlap_framer_core test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/adof_pkg.sv
rtl/adof_ram.sv
rtl/adof_front.sv
rtl/adof_queue.sv
rtl/adof_back.sv
rtl/audio_decode_overlap_framer_core.sv
rtl/adof_checker.sv
tb/tb_audio_decode_overlap_framer_core.sv
